// ===== hw/rtl/printable_run_extractor_assert.svh =====
// Assertion macros for the printable run extractor.
// Files that check their own logic include this header; it depends on clk_i and rst_ni in scope.
`ifndef PRINTABLE_RUN_EXTRACTOR_ASSERT_SVH
`define PRINTABLE_RUN_EXTRACTOR_ASSERT_SVH

// Checked only while out of reset.
`define PRE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");

// Checked at every edge, reset included.
`define PRE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("%m: assertion failed");

`endif

// ===== hw/rtl/pre_pkg.sv =====
// Shared types and constants for the printable run extractor.
// No dependencies; pre_ctrl, the top level and the testbench import this package.
package pre_pkg;

  localparam int unsigned RunCapacityDef = 64;
  localparam int unsigned MinRunDef      = 4;
  localparam int unsigned CapW           = 16;

  localparam logic [CapW-1:0] CapReset    = 16'd4096;
  localparam logic [7:0]      NewlineByte = 8'h0A;
  localparam logic [7:0]      PrintLo     = 8'h20;
  localparam logic [7:0]      PrintHi     = 8'h7E;

  typedef enum logic [0:0] {
    ActData = 1'b0,
    ActEof  = 1'b1
  } action_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] data_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       line_end;
  } out_req_t;

  typedef logic [CapW-1:0] cfg_req_t;

  typedef enum logic [1:0] {
    StIdle,
    StCheck,
    StSend,
    StLine
  } state_e;

endpackage

// ===== hw/rtl/pre_chan_if.sv =====
// Valid/ready channel interface used for the input, output and configuration ports.
// The payload type is set by the instantiating code, normally a pre_pkg struct.
interface pre_chan_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ===== hw/rtl/pre_run_store.sv =====
// Run store: single write port, single registered read port.
// Depends on nothing but its parameters.
module pre_run_store #(
  parameter int unsigned DEPTH = 63,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== hw/rtl/pre_ctrl.sv =====
// Sequencer of the printable run extractor: run tracking, budget check and byte emission.
// Depends on pre_pkg, pre_chan_if and the assertion macro header.
`include "printable_run_extractor_assert.svh"

module pre_ctrl import pre_pkg::*; #(
  parameter int unsigned RUN_CAPACITY = RunCapacityDef,
  parameter int unsigned MIN_RUN      = MinRunDef,
  localparam int unsigned LW          = $clog2(RUN_CAPACITY),
  localparam int unsigned AW          = $clog2(RUN_CAPACITY - 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CapW-1:0] cap_i,
  pre_chan_if.sink        in_i,
  pre_chan_if.source      out_o,
  output logic            wr_en_o,
  output logic [AW-1:0]   wr_addr_o,
  output logic [7:0]      wr_data_o,
  output logic            rd_en_o,
  output logic [AW-1:0]   rd_addr_o,
  input  logic [7:0]      rd_data_i
);

  localparam logic [LW-1:0] LastLen = LW'(RUN_CAPACITY - 1);
  localparam logic [LW-1:0] MinLen  = LW'(MIN_RUN);
  localparam int unsigned   SumW    = CapW + 1;

  state_e          state_q, state_d;
  logic [LW-1:0]   run_len_q, run_len_d;
  logic [LW-1:0]   emit_len_q, emit_len_d;
  logic [LW-1:0]   idx_q, idx_d;
  logic [CapW-1:0] sent_q, sent_d;
  logic            stopped_q, stopped_d;

  in_req_t         req;
  logic            accept;
  logic            printable;
  logic            take_byte;
  logic            start_emit;
  logic            fits;
  logic            out_valid;
  logic            last_byte;
  logic [SumW-1:0] need;

  // Decode of the incoming request and of the budget.
  always_comb begin
    req        = in_i.payload;
    accept     = in_i.valid && (state_q == StIdle);
    printable  = (req.data_byte >= PrintLo) && (req.data_byte <= PrintHi);
    take_byte  = accept && !stopped_q && (req.action == ActData) && printable;
    start_emit = 1'b0;
    if (accept && !stopped_q) begin
      if (take_byte) begin
        start_emit = (run_len_q == LastLen - LW'(1));
      end else begin
        start_emit = (run_len_q >= MinLen);
      end
    end
    need      = SumW'(sent_q) + SumW'(emit_len_q) + SumW'(2);
    fits      = need <= SumW'(cap_i);
    out_valid = (state_q == StSend) || (state_q == StLine);
    last_byte = (idx_q == emit_len_q - LW'(1));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (start_emit) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        state_d = fits ? StSend : StIdle;
      end
      StSend: begin
        if (out_o.ready && last_byte) begin
          state_d = StLine;
        end
      end
      StLine: begin
        if (out_o.ready) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    run_len_d  = run_len_q;
    emit_len_d = emit_len_q;
    idx_d      = idx_q;
    sent_d     = sent_q;
    stopped_d  = stopped_q;
    wr_en_o    = take_byte;
    wr_addr_o  = run_len_q[AW-1:0];
    wr_data_o  = req.data_byte;
    rd_en_o    = 1'b0;
    rd_addr_o  = '0;

    unique case (state_q)
      StIdle: begin
        if (accept && !stopped_q) begin
          if (take_byte && !start_emit) begin
            run_len_d = run_len_q + LW'(1);
          end else begin
            run_len_d = '0;
          end
          if (start_emit) begin
            emit_len_d = take_byte ? LastLen : run_len_q;
          end
        end
      end
      StCheck: begin
        if (fits) begin
          sent_d  = sent_q + CapW'(emit_len_q) + CapW'(1);
          idx_d   = '0;
          rd_en_o = 1'b1;
        end else begin
          stopped_d = 1'b1;
        end
      end
      StSend: begin
        if (out_o.ready && !last_byte) begin
          idx_d     = idx_q + LW'(1);
          rd_en_o   = 1'b1;
          rd_addr_o = idx_d[AW-1:0];
        end
      end
      StLine: begin
      end
      default: begin
      end
    endcase
  end

  assign in_i.ready             = (state_q == StIdle);
  assign out_o.valid            = out_valid;
  assign out_o.payload.out_byte = (state_q == StLine) ? NewlineByte : rd_data_i;
  assign out_o.payload.line_end = (state_q == StLine);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      run_len_q  <= '0;
      emit_len_q <= '0;
      idx_q      <= '0;
      sent_q     <= '0;
      stopped_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      run_len_q  <= run_len_d;
      emit_len_q <= emit_len_d;
      idx_q      <= idx_d;
      sent_q     <= sent_d;
      stopped_q  <= stopped_d;
    end
  end

  `PRE_ASSERT_ALWAYS(a_run_len_bound, run_len_q < LastLen)
  `PRE_ASSERT(a_stop_sticky, stopped_q |=> stopped_q)
  `PRE_ASSERT(a_no_emit_stopped, stopped_q |-> !out_valid)
  `PRE_ASSERT(a_idx_bound, (state_q == StSend) |-> (idx_q < emit_len_q))

endmodule

// ===== hw/rtl/printable_run_extractor.sv =====
// An item that ends no emitted line is taken in StIdle and leaves ready high.
// An item that emits a run of L bytes is accepted in StIdle, checked against the budget in
// StCheck and, if it fits, sent as L + 1 bytes (run and newline), one per granted request.
// Throughput is set by the single emit sequencer, one store entry a cycle while out_o.ready.
// Reset (rst_ni low, asynchronous) clears run length, emitted count and the stop flag,
// and loads the output capacity with 4096; run store contents are not cleared.
module printable_run_extractor import pre_pkg::*; #(
  parameter int unsigned RUN_CAPACITY = RunCapacityDef,
  parameter int unsigned MIN_RUN      = MinRunDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pre_chan_if.sink   cfg_i,
  pre_chan_if.sink   in_i,
  pre_chan_if.source out_o
);

  // The run store keeps one entry fewer than the run capacity, because a run that reaches
  // that length is flushed immediately.
  localparam int unsigned Depth = RUN_CAPACITY - 1;
  localparam int unsigned AW    = $clog2(Depth);

  // The output capacity register. Configuration requests are always taken; the user must
  // send them only while the block is idle, so lines see no change; it is not enforced.
  logic [CapW-1:0] cap_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_i.valid) begin
      cap_q <= cfg_i.payload;
    end
  end

  // Memory port wiring between the sequencer and the run store.
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  // The run store is written once per accepted printable byte until the block stops.
  // During emission the sequencer reads one entry ahead, so the registered read data is
  // already the next run byte when the output request is granted.
  pre_run_store #(
    .DEPTH (Depth),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // The sequencer tracks the current run, checks each line against the remaining budget,
  // and stops the block for good the first time a line does not fit.
  pre_ctrl #(
    .RUN_CAPACITY (RUN_CAPACITY),
    .MIN_RUN      (MIN_RUN)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cap_i     (cap_q),
    .in_i      (in_i),
    .out_o     (out_o),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data)
  );

endmodule

// ===== dv/printable_run_extractor_tb.sv =====
// Self-checking testbench for printable_run_extractor: directed and random byte streams.
// A scoreboard class predicts every emitted byte; depends on pre_pkg and pre_chan_if.
module printable_run_extractor_tb import pre_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // The receiver holds off this long once, so that the block fills up and stalls its input.
  localparam int unsigned HoldCycles  = 300;
  // The run ends as failed if this many cycles pass with no request moving on any channel.
  localparam int unsigned QuietLimit  = 3000;
  // Cycles the block may still be busy after the last expected byte has come.
  localparam int unsigned SettleCycles = 8;

  // Tracks the run being gathered and queues the bytes the block must emit.
  class line_scoreboard;
    logic [7:0]  run_bytes[RunCapacityDef-1];
    int unsigned run_len;
    bit [15:0]   emitted;
    bit          halted;
    cfg_req_t    capacity = CapReset;
    out_req_t    expected_bytes[$];
    int unsigned mismatches;

    function void set_capacity(cfg_req_t c);
      capacity = c;
    endfunction

    // A line needs its characters, the newline and one spare slot; if that does not fit,
    // the block goes quiet for the rest of the run.
    function void emit_line();
      if (int'(emitted) + int'(run_len) + 2 > int'(capacity)) begin
        halted = 1'b1;
        return;
      end
      for (int unsigned k = 0; k < run_len; k++) begin
        expected_bytes.push_back('{out_byte: run_bytes[k], line_end: 1'b0});
      end
      expected_bytes.push_back('{out_byte: NewlineByte, line_end: 1'b1});
      emitted = emitted + 16'(run_len + 1);
    endfunction

    function void take_byte_request(in_req_t r);
      if (halted) return;
      if (r.action == ActEof) begin
        if (run_len >= MinRunDef) emit_line();
        run_len = 0;
      end else if (r.data_byte >= PrintLo && r.data_byte <= PrintHi) begin
        if (run_len < RunCapacityDef - 1) begin
          run_bytes[run_len] = r.data_byte;
          run_len++;
        end
        // A full store is emitted at once and a fresh run starts.
        if (run_len + 1 >= RunCapacityDef) begin
          emit_line();
          run_len = 0;
        end
      end else begin
        if (run_len >= MinRunDef) emit_line();
        run_len = 0;
      end
    endfunction

    function void check_line_byte(out_req_t got);
      out_req_t want;
      if (expected_bytes.size() == 0) begin
        $display("%0t: byte %02h line_end %0b arrived with nothing expected",
                 $time, got.out_byte, got.line_end);
        mismatches++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $display("%0t: out_byte expected %02h, got %02h", $time, want.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.line_end !== want.line_end) begin
        $display("%0t: line_end expected %0b, got %0b", $time, want.line_end, got.line_end);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  pre_chan_if #(.T(cfg_req_t)) cfg_if ();
  pre_chan_if #(.T(in_req_t))  in_if ();
  pre_chan_if #(.T(out_req_t)) out_if ();

  printable_run_extractor dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  line_scoreboard sb = new;

  // Set by the stimulus to turn off all idling on both sides for a stretch.
  bit          no_idle;
  // Set by the stimulus; the receiver clears it once its long hold-off is over.
  bit          hold_req;
  int unsigned items_sent;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every accepted request is sampled at the clock edge, before any driver or the block
  // updates its outputs, so the order of processes within the step does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.take_byte_request(in_if.payload);
      if (out_if.valid && out_if.ready) sb.check_line_byte(out_if.payload);
    end
  end

  // Watchdog: a run that makes no progress on any channel for too long is a failure.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no request moved for %0d cycles", $time, QuietLimit);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result receiver: a random stall before each result, or none in a no-idle stretch.
  // Once asked, it keeps ready low for a long stretch while the sender keeps going.
  initial begin : result_sink
    int unsigned stall;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
    end
  end

  // Offers one byte request after a random gap and returns at the edge that takes it.
  // Valid stays high into the next request when no gap is drawn.
  task automatic send_req(action_e act, logic [7:0] b);
    int unsigned gap;
    in_req_t     req;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    req.action    = act;
    req.data_byte = b;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= req;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_run(int unsigned len);
    for (int unsigned k = 0; k < len; k++) begin
      send_req(ActData, 8'($urandom_range(PrintLo, PrintHi)));
    end
  endtask

  // Closes a run with end of file or with a control byte from either side of the
  // printable range.
  task automatic end_run();
    case ($urandom_range(0, 2))
      0: send_req(ActEof, 8'($urandom));
      1: send_req(ActData, 8'($urandom_range(0, PrintLo - 1)));
      default: send_req(ActData, 8'($urandom_range(PrintHi + 1, 255)));
    endcase
  endtask

  // Mostly well-formed runs of random text. Lengths cluster around the minimum, a tenth
  // of the picks are long runs around the store size, and a fifth are stray bytes.
  task automatic random_traffic(int unsigned n);
    int unsigned stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0: begin
          send_run($urandom_range(58, 70));
          end_run();
        end
        1, 2: send_req(action_e'($urandom_range(0, 1)), 8'($urandom));
        default: begin
          send_run($urandom_range(1, 12));
          end_run();
        end
      endcase
    end
  endtask

  // Waits until every expected byte has come and the block has had time to settle,
  // so that the register can be written while it is idle. The first edge lets the
  // scoreboard note the last accepted request before the queue is looked at.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_capacity(cfg_req_t c);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= c;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    sb.set_capacity(c);
  endtask

  initial begin : stimulus
    rst_n          = 1'b0;
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.payload <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with the capacity left at its reset value.
    // A two-byte run ended by a zero byte is too short and is dropped.
    send_req(ActData, "a");
    send_req(ActData, "b");
    send_req(ActData, 8'h00);
    // A run of exactly the minimum length, made of both printable limits, closed by DEL.
    send_req(ActData, PrintLo);
    send_req(ActData, "Q");
    send_req(ActData, "z");
    send_req(ActData, PrintHi);
    send_req(ActData, 8'h7F);
    // End of file flushes a run; its data byte is ignored.
    send_req(ActData, "w");
    send_req(ActData, "x");
    send_req(ActData, "y");
    send_req(ActData, "z");
    send_req(ActEof, 8'hFF);
    // End of file with no run open emits nothing.
    send_req(ActEof, 8'h41);
    // Control bytes just below the printable range and in the upper half of the byte range.
    send_req(ActData, 8'h1F);
    send_req(ActData, 8'hFF);
    send_req(ActData, 8'h80);
    // A short run at end of file is dropped, and the budget count carries on after it.
    send_req(ActData, "a");
    send_req(ActData, "b");
    send_req(ActData, "c");
    send_req(ActEof, 8'h00);
    wait_drained();

    // Largest budget: random traffic with idling, then a stretch with none in which the
    // receiver holds off while long runs keep coming, so the input backs up.
    write_capacity(16'hFFFF);
    no_idle = 1'b0;
    random_traffic(50);
    no_idle  = 1'b1;
    hold_req = 1'b1;
    send_run(63);
    send_run(40);
    end_run();
    random_traffic(40);
    no_idle = 1'b0;
    random_traffic(30);
    wait_drained();

    // A random budget with room to spare for the rest of the random traffic.
    write_capacity(16'($urandom_range(int'(sb.emitted) + 600, 65535)));
    random_traffic(60);
    no_idle = 1'b1;
    random_traffic(40);
    no_idle = 1'b0;
    // Close whatever run is open so the next budget can be set exactly.
    send_req(ActEof, 8'($urandom));
    wait_drained();

    // A ten-character line that fits the budget to the last byte.
    write_capacity(16'(int'(sb.emitted) + 12));
    send_run(10);
    send_req(ActData, NewlineByte);
    wait_drained();

    // Smallest budget, below the count already emitted: the next line stops the block,
    // and everything after that is ignored.
    write_capacity(16'd2);
    send_run(4);
    send_req(ActEof, 8'($urandom));
    random_traffic(20);
    wait_drained();
    repeat (20) @(posedge clk);

    if (sb.expected_bytes.size() != 0) begin
      $display("%0t: %0d expected bytes never arrived", $time, sb.expected_bytes.size());
    end
    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/pre_pkg.sv
hw/rtl/pre_chan_if.sv
hw/rtl/pre_run_store.sv
hw/rtl/pre_ctrl.sv
hw/rtl/printable_run_extractor.sv
dv/printable_run_extractor_tb.sv
